>>> hdl/dtpc_pkg.sv
// Shared types, constants and helpers for the depth-to-point-cloud block.
// No dependencies; every other file of the block imports this package.
package dtpc_pkg;

	localparam int MAX_IMAGE_DIM = 4096;
	localparam int CNT_W         = $clog2(MAX_IMAGE_DIM);
	localparam int DIM_W         = 13;
	localparam int DEPTH_W       = 16;
	localparam int COLOR_W       = 8;
	localparam int Q4_W          = 16;
	localparam int RECIP_W       = 24;
	localparam int RECIP_HALF_W  = RECIP_W / 2;
	localparam int COORD_W       = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 24;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_DEPTH_SCALE  = 3'd2,
		REG_CENTER_X     = 3'd3,
		REG_CENTER_Y     = 3'd4,
		REG_INV_FOCAL_X  = 3'd5,
		REG_INV_FOCAL_Y  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]   image_width;
		logic [DIM_W-1:0]   image_height;
		logic [RECIP_W-1:0] depth_scale;
		logic [Q4_W-1:0]    center_x;
		logic [Q4_W-1:0]    center_y;
		logic [RECIP_W-1:0] inv_focal_x;
		logic [RECIP_W-1:0] inv_focal_y;
	} cfg_t;

	// One queued pixel: offsets from the principal point as sign and magnitude.
	typedef struct packed {
		logic [DEPTH_W-1:0] depth_value;
		logic               x_neg;
		logic [Q4_W-1:0]    x_mag;
		logic               y_neg;
		logic [Q4_W-1:0]    y_mag;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} qentry_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} qstat_t;

	// Treat zero as one and anything above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_IMAGE_DIM))
			r = DIM_W'(MAX_IMAGE_DIM);
		return r;
	endfunction

endpackage

>>> hdl/dtpc_pixel_if.sv
// Pixel channel: valid/ready handshake with depth and BGR colour payload.
// Depends on dtpc_pkg.
interface dtpc_pixel_if import dtpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] depth_value;
	logic [COLOR_W-1:0] blue;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] red;

	modport source (output valid, depth_value, blue, green, red, input ready);
	modport sink (input valid, depth_value, blue, green, red, output ready);
endinterface

>>> hdl/dtpc_point_if.sv
// Point channel: valid/ready handshake with Q16.16 coordinates and colour.
// Depends on dtpc_pkg.
interface dtpc_point_if import dtpc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [COORD_W-1:0]        point_z;
	logic [COLOR_W-1:0]        out_blue;
	logic [COLOR_W-1:0]        out_green;
	logic [COLOR_W-1:0]        out_red;

	modport source (output valid, point_x, point_y, point_z, out_blue, out_green, out_red,
		input ready);
	modport sink (input valid, point_x, point_y, point_z, out_blue, out_green, out_red,
		output ready);
endinterface

>>> hdl/dtpc_front.sv
// Front end: accepts pixels, tracks raster position, drops empty depth samples.
// Depends on dtpc_pkg and dtpc_pixel_if.
module dtpc_front import dtpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	dtpc_pixel_if.sink   pix,
	input  qstat_t       q_stat,
	output logic         push,
	output qentry_t      entry
);

	logic [CNT_W-1:0] col_q, row_q;
	logic [DIM_W-1:0] eff_w, eff_h, col_inc, row_inc;
	logic [Q4_W-1:0]  pos_x, pos_y;
	logic             accept;

	assign pix.ready = !q_stat.full;
	assign accept    = pix.valid && pix.ready;
	assign push      = accept && (pix.depth_value != '0);

	assign eff_w   = clamp_dim(cfg.image_width);
	assign eff_h   = clamp_dim(cfg.image_height);
	assign col_inc = {1'b0, col_q} + DIM_W'(1);
	assign row_inc = {1'b0, row_q} + DIM_W'(1);

	assign pos_x = {col_q, 4'b0000};
	assign pos_y = {row_q, 4'b0000};

	always_comb begin
		entry.depth_value = pix.depth_value;
		entry.x_neg       = pos_x < cfg.center_x;
		entry.x_mag       = entry.x_neg ? (cfg.center_x - pos_x) : (pos_x - cfg.center_x);
		entry.y_neg       = pos_y < cfg.center_y;
		entry.y_mag       = entry.y_neg ? (cfg.center_y - pos_y) : (pos_y - cfg.center_y);
		entry.blue        = pix.blue;
		entry.green       = pix.green;
		entry.red         = pix.red;
	end

	// Advance the raster counters on every accepted word, empty depth or not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= eff_w) begin
				col_q <= '0;
				row_q <= (row_inc >= eff_h) ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
			end
		end
	end

endmodule

>>> hdl/dtpc_queue.sv
// Short first-in first-out queue between the front and back ends.
// Depends on dtpc_pkg.
module dtpc_queue import dtpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  qentry_t push_entry,
	input  logic    pop,
	output qentry_t head,
	output qstat_t  q_stat
);

	qentry_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign q_stat.count = count_q;
	assign q_stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

>>> hdl/dtpc_back.sv
// Back end: four-stage projection pipeline with registered point output.
// Depends on dtpc_pkg and dtpc_point_if.
module dtpc_back import dtpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  qentry_t     head,
	input  qstat_t      q_stat,
	output logic        pop,
	dtpc_point_if.source pts
);

	localparam int ZPROD_W = DEPTH_W + RECIP_W;
	localparam int T_W     = Q4_W + COORD_W;
	localparam int A_W     = T_W + RECIP_HALF_W;
	localparam int B_W     = A_W + 1;
	localparam int R_W     = B_W - 16;

	logic                 en, out_valid_q;
	logic                 v_s1, v_s2, v_s3;
	logic [ZPROD_W-1:0]   zprod;
	logic [COORD_W-1:0]   z_s1, z_s2, z_s3;
	logic                 xneg_s1, yneg_s1, xneg_s2, yneg_s2, xneg_s3, yneg_s3;
	logic [Q4_W-1:0]      xmag_s1, ymag_s1;
	logic [T_W-1:0]       tx_s2, ty_s2;
	logic [A_W-1:0]       ax_s3, ay_s3;
	logic [B_W-1:0]       bx_s3, by_s3;
	logic [3*COLOR_W-1:0] bgr_s1, bgr_s2, bgr_s3;

	// Combine the split products, round half up, apply sign and saturate.
	function automatic logic [COORD_W-1:0] finish(input logic neg, input logic [A_W-1:0] a,
		input logic [B_W-1:0] b);
		logic [B_W-1:0] sum;
		logic [R_W-1:0] r;
		logic [COORD_W-1:0] res;
		sum = B_W'(a) + B_W'(b[B_W-1:RECIP_HALF_W]);
		r   = sum[B_W-1:16];
		if (neg) begin
			if (r > R_W'(33'h8000_0000))
				res = 32'h8000_0000;
			else
				res = 32'd0 - r[COORD_W-1:0];
		end else begin
			if (r > R_W'(32'h7FFF_FFFF))
				res = 32'h7FFF_FFFF;
			else
				res = r[COORD_W-1:0];
		end
		return res;
	endfunction

	// Whole pipeline moves together whenever the output register can load.
	assign en    = !out_valid_q || pts.ready;
	assign pop   = en && !q_stat.empty;
	assign zprod = ZPROD_W'(head.depth_value) * ZPROD_W'(cfg.depth_scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= !q_stat.empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= COORD_W'((zprod + ZPROD_W'(128)) >> 8);
			xneg_s1 <= head.x_neg;
			yneg_s1 <= head.y_neg;
			xmag_s1 <= head.x_mag;
			ymag_s1 <= head.y_mag;
			bgr_s1  <= {head.blue, head.green, head.red};

			tx_s2   <= T_W'(xmag_s1) * T_W'(z_s1);
			ty_s2   <= T_W'(ymag_s1) * T_W'(z_s1);
			z_s2    <= z_s1;
			xneg_s2 <= xneg_s1;
			yneg_s2 <= yneg_s1;
			bgr_s2  <= bgr_s1;

			ax_s3   <= A_W'(tx_s2) * A_W'(cfg.inv_focal_x[RECIP_W-1:RECIP_HALF_W]);
			ay_s3   <= A_W'(ty_s2) * A_W'(cfg.inv_focal_y[RECIP_W-1:RECIP_HALF_W]);
			bx_s3   <= B_W'(tx_s2) * B_W'(cfg.inv_focal_x[RECIP_HALF_W-1:0])
				+ (B_W'(1) << 27);
			by_s3   <= B_W'(ty_s2) * B_W'(cfg.inv_focal_y[RECIP_HALF_W-1:0])
				+ (B_W'(1) << 27);
			z_s3    <= z_s2;
			xneg_s3 <= xneg_s2;
			yneg_s3 <= yneg_s2;
			bgr_s3  <= bgr_s2;

			if (v_s3) begin
				pts.point_x   <= finish(xneg_s3, ax_s3, bx_s3);
				pts.point_y   <= finish(yneg_s3, ay_s3, by_s3);
				pts.point_z   <= z_s3;
				pts.out_blue  <= bgr_s3[3*COLOR_W-1:2*COLOR_W];
				pts.out_green <= bgr_s3[2*COLOR_W-1:COLOR_W];
				pts.out_red   <= bgr_s3[COLOR_W-1:0];
			end
		end
	end

	assign pts.valid = out_valid_q;

endmodule

>>> hdl/depth_to_point_cloud.sv
// Top level of the depth-to-point-cloud block: configuration registers and
// the front end, queue and back end. Depends on dtpc_pkg and both interfaces.
//
// Usage:
//  - pix carries one pixel per word (depth plus BGR colour) in raster order;
//    column and row counters wrap at the configured image size.
//  - A pixel with zero depth is consumed and counted but yields no word on pts.
//  - Every other pixel yields one point word on pts: z = depth*scale, and
//    x, y back-projected through the pinhole model, saturated, in Q16.16.
//  - A point passes through the queue, the back-end stages and the output register before it is valid on pts.
//  - Throughput: one pixel per cycle while the queue has space; the multiplier pipeline in the back
//    end starts one point per cycle whenever its output register can load and the queue holds a pixel.
//  - The back end stalls as a whole while pts is held; the four-word queue
//    keeps taking pixels until it fills, then pix.ready drops.
//  - cfg_we/cfg_index/cfg_data write one register per cycle; write only
//    while no pixel is in flight. Indexes beyond the register list are ignored.
//  - Reset loads the default camera setup (640x480) and clears counters,
//    queue and pipeline; no point is pending after reset.
module depth_to_point_cloud import dtpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	dtpc_pixel_if.sink            pix,
	dtpc_point_if.source          pts,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	qentry_t push_entry, head;
	qstat_t  q_stat;
	logic    push, pop;

	// Register file: decode the index and load the addressed field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= DIM_W'(640);
			cfg_q.image_height <= DIM_W'(480);
			cfg_q.depth_scale  <= RECIP_W'(16777);
			cfg_q.center_x     <= Q4_W'(5120);
			cfg_q.center_y     <= Q4_W'(3840);
			cfg_q.inv_focal_x  <= RECIP_W'(33554);
			cfg_q.inv_focal_y  <= RECIP_W'(33554);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[DIM_W-1:0];
				REG_DEPTH_SCALE:  cfg_q.depth_scale  <= cfg_data[RECIP_W-1:0];
				REG_CENTER_X:     cfg_q.center_x     <= cfg_data[Q4_W-1:0];
				REG_CENTER_Y:     cfg_q.center_y     <= cfg_data[Q4_W-1:0];
				REG_INV_FOCAL_X:  cfg_q.inv_focal_x  <= cfg_data[RECIP_W-1:0];
				REG_INV_FOCAL_Y:  cfg_q.inv_focal_y  <= cfg_data[RECIP_W-1:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	// Front: count raster position and queue pixels that carry depth.
	dtpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.pix    (pix),
		.q_stat (q_stat),
		.push   (push),
		.entry  (push_entry)
	);

	// Decouple the two ends so each can stall on its own.
	dtpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// Back: multiply out z, x and y and hold the point for the receiver.
	dtpc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.pts    (pts)
	);

	// Queue occupancy never exceeds its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// Pixels are refused exactly when the queue is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix.ready == !q_stat.full)
		else $error("pixel ready does not follow queue space");

	// An empty-depth pixel never adds a queue entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready && pix.depth_value == '0) |=> q_stat.count <= $past(q_stat.count))
		else $error("zero-depth pixel entered the queue");

endmodule
